// ----- hw/rtl/dpcm_dec_pkg.sv -----
`default_nettype none

package dpcm_dec_pkg;

    localparam int CODE_W    = 8;
    localparam int SAMPLE_W  = 16;
    localparam int MAG_W     = 15;
    localparam int TAB_DEPTH = 128;
    localparam int CFG_W     = 2;
    localparam int CFG_IDX_W = 1;

    localparam int MAX_CHANNELS_DEF = 2;

    // Constants of the exponential curve recurrence.
    localparam longint EXP_MUL   = 441;
    localparam longint EXP_BIAS  = 3103;
    localparam longint EXP_DIV   = 6206;
    localparam longint EXP_FLOOR = 256;
    localparam longint EXP_ROUND = 128;
    localparam longint MAG_MAX   = 32767;

    typedef enum logic [1:0] {
        MODE_SQUARE = 2'd0,
        MODE_CUBE   = 2'd1,
        MODE_EXP    = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TABLE_MODE    = 1'b0,
        CFG_CHANNEL_COUNT = 1'b1
    } cfg_idx_t;

    localparam logic [CFG_W-1:0] TABLE_MODE_RST    = 2'd0;
    localparam logic [CFG_W-1:0] CHANNEL_COUNT_RST = 2'd2;
    localparam logic [CFG_W-1:0] CHANNELS_MONO     = 2'd1;

    typedef logic [TAB_DEPTH-1:0][MAG_W-1:0] mag_tab_t;

    function automatic mag_tab_t square_table();
        mag_tab_t t;
        for (int i = 0; i < TAB_DEPTH; i++) begin
            t[i] = MAG_W'(i * i * 2);
        end
        return t;
    endfunction

    function automatic mag_tab_t cube_table();
        mag_tab_t t;
        for (int i = 0; i < TAB_DEPTH; i++) begin
            t[i] = MAG_W'((i * i * i) / 64);
        end
        return t;
    endfunction

    // Runs the recurrence once per magnitude while building the table.
    function automatic mag_tab_t exp_table();
        mag_tab_t t;
        longint   s;
        longint   step;
        longint   v;
        s = 0;
        for (int i = 0; i < TAB_DEPTH; i++) begin
            v = (s + EXP_ROUND) >>> 8;
            if (v > MAG_MAX) begin
                v = MAG_MAX;
            end
            t[i] = MAG_W'(v);
            step = (s * EXP_MUL + EXP_BIAS) / EXP_DIV;
            if (step < EXP_FLOOR) begin
                step = EXP_FLOOR;
            end
            s = s + step;
        end
        return t;
    endfunction

    localparam mag_tab_t SQUARE_TAB = square_table();
    localparam mag_tab_t CUBE_TAB   = cube_table();
    localparam mag_tab_t EXP_TAB    = exp_table();

endpackage

`default_nettype wire

// ----- hw/rtl/dpcm_dec_curve.sv -----
`default_nettype none

module dpcm_dec_curve (
    input  wire logic signed [dpcm_dec_pkg::CODE_W-1:0]   code,
    input  wire logic        [dpcm_dec_pkg::CFG_W-1:0]    table_mode,
    output logic signed      [dpcm_dec_pkg::SAMPLE_W-1:0] tval,
    output logic                                          bad_code
);
    import dpcm_dec_pkg::*;

    logic [CODE_W-1:0] abs_code;
    logic [6:0]        mag;
    logic [MAG_W-1:0]  tab_val;

    assign abs_code = code[CODE_W-1] ? CODE_W'(-code) : code;
    assign mag      = abs_code[6:0];
    assign bad_code = (code == -8'sd128);

    always_comb begin
        unique case (table_mode)
            MODE_CUBE: tab_val = CUBE_TAB[mag];
            MODE_EXP:  tab_val = EXP_TAB[mag];
            default:   tab_val = SQUARE_TAB[mag];
        endcase
    end

    // The most negative code is invalid and decodes to zero.
    always_comb begin
        priority if (bad_code) begin
            tval = '0;
        end else if (code[CODE_W-1]) begin
            tval = -$signed({1'b0, tab_val});
        end else begin
            tval = $signed({1'b0, tab_val});
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dpcm_table_audio_decoder.sv -----
`default_nettype none
// Pipeline: a word accepted on the input is held in the input register, and its result is
// registered on the result port when the word advances, once the result port is free.
// Throughput: one word per cycle while m_ready does not stall the output; the per-channel
// level is read and written by the single table lookup, add and clip stage, so each word
// sees the level of the one before. Reset (synchronous, active low) zeroes every channel
// level, empties both stages and sets table_mode to square law and channel_count to stereo.

module dpcm_table_audio_decoder #(
    parameter int MAX_CHANNELS = dpcm_dec_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic                                          aclk,
    input  wire logic                                          aresetn,
    input  wire logic                                          cfg_wr_en,
    input  wire logic        [dpcm_dec_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic        [dpcm_dec_pkg::CFG_W-1:0]         cfg_wdata,
    input  wire logic                                          s_valid,
    output logic                                               s_ready,
    input  wire logic signed [dpcm_dec_pkg::CODE_W-1:0]        s_code,
    input  wire logic                                          s_channel,
    output logic                                               m_valid,
    input  wire logic                                          m_ready,
    output logic signed      [dpcm_dec_pkg::SAMPLE_W-1:0]      m_sample,
    output logic                                               m_was_delta,
    output logic                                               m_bad_code
);
    import dpcm_dec_pkg::*;

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [CFG_W-1:0] table_mode_reg;
    logic [CFG_W-1:0] channel_count_reg;

    logic                     in_valid_reg;
    logic signed [CODE_W-1:0] code_reg;
    logic                     channel_reg;

    logic signed [SAMPLE_W-1:0] level_reg [MAX_CHANNELS];

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       was_delta_reg;
    logic                       bad_code_reg;

    logic                       advance;
    logic                       eff_channel;
    logic [CH_W-1:0]            ch_sel;
    logic signed [SAMPLE_W-1:0] tval;
    logic                       bad_code;
    logic signed [SAMPLE_W:0]   sum;
    logic signed [SAMPLE_W-1:0] level_next;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign eff_channel = (channel_count_reg == CHANNELS_MONO) ? 1'b0 : channel_reg;
    assign ch_sel = (int'(eff_channel) < MAX_CHANNELS) ? CH_W'(eff_channel) : '0;

    dpcm_dec_curve u_curve (
        .code       (code_reg),
        .table_mode (table_mode_reg),
        .tval       (tval),
        .bad_code   (bad_code)
    );

    assign sum = {level_reg[ch_sel][SAMPLE_W-1], level_reg[ch_sel]}
               + {tval[SAMPLE_W-1], tval};

    // An odd code is a delta and saturates; an even code loads the level directly.
    always_comb begin
        priority if (!code_reg[0]) begin
            level_next = tval;
        end else if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
            level_next = sum[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                       : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else begin
            level_next = sum[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_mode_reg    <= TABLE_MODE_RST;
            channel_count_reg <= CHANNEL_COUNT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TABLE_MODE:    table_mode_reg    <= cfg_wdata;
                CFG_CHANNEL_COUNT: channel_count_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            code_reg    <= s_code;
            channel_reg <= s_channel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                level_reg[i] <= '0;
            end
        end else if (advance) begin
            level_reg[ch_sel] <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sample_reg    <= level_next;
            was_delta_reg <= code_reg[0];
            bad_code_reg  <= bad_code;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_sample    = sample_reg;
    assign m_was_delta = was_delta_reg;
    assign m_bad_code  = bad_code_reg;

endmodule

`default_nettype wire
